### hdl/asfc_pkg.sv
package asfc_pkg;

    localparam logic [15:0] CRC_POLY    = 16'h8005;
    localparam logic [15:0] SYNC_CRC    = 16'hAC41;
    localparam logic [15:0] SYNC_PLAIN  = 16'hAC40;
    localparam logic [23:0] SIZE_ESCAPE = 24'h00FFFF;
    localparam logic [7:0]  ESCAPE_BYTE = 8'hFF;

    // one classified input item, handed from front to back
    typedef struct packed {
        logic        start;       // item opens a new frame: header first
        logic        sync_crc;    // sync word carries the crc flag
        logic        escape;      // size goes out as escape plus 3 bytes
        logic        has_data;    // item carries a payload byte
        logic        finish;      // item completes the frame
        logic        crc_append;  // crc bytes follow the last payload byte
        logic [23:0] len;
        logic [7:0]  data;
    } t_cmd;

    // byte slots of the sync frame, in emission order
    typedef enum logic [3:0] {
        ST_SYNC_HI,
        ST_SYNC_LO,
        ST_ESC_HI,
        ST_ESC_LO,
        ST_LEN2,
        ST_LEN1,
        ST_LEN0,
        ST_DATA,
        ST_CRC_HI,
        ST_CRC_LO
    } t_step;

    // crc-16, msb first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

### hdl/asfc_front.sv
module asfc_front
    import asfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic        i_start,
    input  logic [23:0] i_len,
    input  logic [7:0]  i_data,
    input  logic        i_crc_enable,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic        r_active;
    logic [23:0] r_remaining;
    logic        n_active;
    logic [23:0] n_remaining;
    logic        w_finish;

    always_comb begin
        o_cmd       = '0;
        o_push      = 1'b0;
        w_finish    = 1'b0;
        n_active    = r_active;
        n_remaining = r_remaining;
        if (i_start) begin
            w_finish    = (i_len == 24'd0) || (i_len == 24'd1);
            o_push      = 1'b1;
            n_active    = ~w_finish;
            n_remaining = (i_len == 24'd0) ? 24'd0 : i_len - 24'd1;
        end else if (r_active) begin
            w_finish    = (r_remaining == 24'd1);
            o_push      = 1'b1;
            n_active    = ~w_finish;
            n_remaining = r_remaining - 24'd1;
        end
        o_cmd.start      = i_start;
        o_cmd.sync_crc   = i_crc_enable;
        o_cmd.escape     = (i_len >= SIZE_ESCAPE);
        o_cmd.has_data   = ~i_start || (i_len != 24'd0);
        o_cmd.finish     = w_finish;
        o_cmd.crc_append = w_finish & i_crc_enable;
        o_cmd.len        = i_len;
        o_cmd.data       = i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_remaining <= '0;
        end else if (i_accept) begin
            r_active    <= n_active;
            r_remaining <= n_remaining;
        end
    end

endmodule

### hdl/asfc_queue.sv
module asfc_queue
    import asfc_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty,
    output logic o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == FULL_CNT);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### hdl/asfc_back.sv
module asfc_back
    import asfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_cmd       i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_eof,
    output logic       o_last
);

    t_step       r_step;
    logic        r_mid;
    logic [15:0] r_crc;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_eof;
    logic        r_out_last;

    t_step       w_cur;
    t_step       n_step;
    logic        w_done;
    logic [7:0]  w_byte;
    logic        w_protect;
    logic        w_advance;

    assign w_cur     = r_mid ? r_step : (i_head.start ? ST_SYNC_HI : ST_DATA);
    assign w_advance = ~i_empty && (~r_out_valid || i_ready);
    assign o_pop     = w_advance && w_done;

    // next slot of the current item
    always_comb begin
        n_step = ST_SYNC_HI;
        w_done = 1'b0;
        case (w_cur)
            ST_SYNC_HI: n_step = ST_SYNC_LO;
            ST_SYNC_LO: n_step = i_head.escape ? ST_ESC_HI : ST_LEN1;
            ST_ESC_HI:  n_step = ST_ESC_LO;
            ST_ESC_LO:  n_step = ST_LEN2;
            ST_LEN2:    n_step = ST_LEN1;
            ST_LEN1:    n_step = ST_LEN0;
            ST_LEN0: begin
                if (i_head.has_data) begin
                    n_step = ST_DATA;
                end else if (i_head.crc_append) begin
                    n_step = ST_CRC_HI;
                end else begin
                    w_done = 1'b1;
                end
            end
            ST_DATA: begin
                if (i_head.crc_append) begin
                    n_step = ST_CRC_HI;
                end else begin
                    w_done = 1'b1;
                end
            end
            ST_CRC_HI:  n_step = ST_CRC_LO;
            ST_CRC_LO:  w_done = 1'b1;
            default:    w_done = 1'b1;
        endcase
    end

    // byte of the current slot
    always_comb begin
        w_byte    = 8'h00;
        w_protect = 1'b0;
        case (w_cur)
            ST_SYNC_HI: w_byte = SYNC_CRC[15:8];
            ST_SYNC_LO: w_byte = i_head.sync_crc ? SYNC_CRC[7:0] : SYNC_PLAIN[7:0];
            ST_ESC_HI: begin
                w_byte    = ESCAPE_BYTE;
                w_protect = 1'b1;
            end
            ST_ESC_LO: begin
                w_byte    = ESCAPE_BYTE;
                w_protect = 1'b1;
            end
            ST_LEN2: begin
                w_byte    = i_head.len[23:16];
                w_protect = 1'b1;
            end
            ST_LEN1: begin
                w_byte    = i_head.len[15:8];
                w_protect = 1'b1;
            end
            ST_LEN0: begin
                w_byte    = i_head.len[7:0];
                w_protect = 1'b1;
            end
            ST_DATA: begin
                w_byte    = i_head.data;
                w_protect = 1'b1;
            end
            ST_CRC_HI:  w_byte = r_crc[15:8];
            ST_CRC_LO:  w_byte = r_crc[7:0];
            default:    w_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_SYNC_HI;
            r_mid       <= 1'b0;
            r_crc       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_step      <= n_step;
            r_mid       <= ~w_done;
            r_out_valid <= 1'b1;
            if (w_cur == ST_SYNC_HI) begin
                r_crc <= '0;
            end else if (w_protect) begin
                r_crc <= crc16_byte(r_crc, w_byte);
            end
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_byte <= w_byte;
            r_out_eof  <= w_done & i_head.finish;
            r_out_last <= w_done;
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_eof   = r_out_eof;
    assign o_last  = r_out_last;

endmodule

### hdl/audio_sync_framer_crc16_top.sv
// sync framer with crc-16: each accepted input beat (frame start with length, or one payload
// byte) is classified by the front end and queued; the back end expands it into output beats,
// one byte per clock while m_axis_tready is high: sync word 0xac41 (crc on) or 0xac40, then
// the frame size as 2 bytes or as 0xffff plus 3 bytes for sizes of 65535 and up, the payload
// bytes, and two crc bytes after the last payload byte when crc is on. the crc (poly 0x8005,
// init 0, msb first) covers the escape bytes, size and payload. a start beat yields 4 to 8
// output beats, a payload beat 1 or 3, so the output port runs at one beat per cycle while
// m_axis_tready is high and the input port takes one beat per cycle as long as the command
// queue (QUEUE_DEPTH entries) has room; input stalls while the queue is full. m_axis_tlast
// marks the final byte of a sync frame, m_axis_tuser the last byte caused by an input beat.
// a start beat abandons an unfinished frame. crc_enable is written through the cfg channel,
// resets to 1, and is to be changed only while the block is idle.
module audio_sync_framer_crc16_top
    import asfc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [23:0] frame_length, [31:24] data_byte
    input  logic        s_axis_tuser,   // [0] frame_start
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,   // end_of_frame
    output logic        m_axis_tuser,   // [0] last_of_run
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data      // crc_enable
);

    logic r_crc_enable;
    logic w_accept;
    logic w_push;
    logic w_pop;
    logic w_empty;
    logic w_full;
    t_cmd w_cmd;
    t_cmd w_head;

    // config register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_enable <= 1'b1;
        end else if (i_cfg_valid) begin
            r_crc_enable <= i_cfg_data;
        end
    end

    // input beat taken whenever the queue has a free entry
    assign s_axis_tready = ~w_full;
    assign w_accept      = s_axis_tvalid & s_axis_tready;

    asfc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_start      (s_axis_tuser),
        .i_len        (s_axis_tdata[23:0]),
        .i_data       (s_axis_tdata[31:24]),
        .i_crc_enable (r_crc_enable),
        .o_push       (w_push),
        .o_cmd        (w_cmd)
    );

    // beats with no frame open produce no command
    asfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept & w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    asfc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_byte  (m_axis_tdata),
        .o_eof   (m_axis_tlast),
        .o_last  (m_axis_tuser)
    );

endmodule

### hdl/asfc_checker.sv
module asfc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       m_axis_tuser
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    // end of frame is always the last byte of its run
    a_eof_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
        else $error("end of frame without end of run");

    // nothing shown right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind audio_sync_framer_crc16_top asfc_checker u_asfc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
